>>> src/midi_track_event_encoder_macros.svh
// Assertion macros shared by the MIDI track event encoder RTL.
`ifndef MIDI_TRACK_EVENT_ENCODER_MACROS_SVH
`define MIDI_TRACK_EVENT_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MTE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mte_pkg.sv
// Types and constants shared by the MIDI track event encoder modules.
`default_nettype none

package mte_pkg;

    // input kind codes
    localparam logic [1:0] KIND_MSG   = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // MIDI command nibbles kept by the recorder
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

    // meta event bytes
    localparam logic [7:0]  META_PREFIX = 8'hFF;
    localparam logic [7:0]  META_TEMPO  = 8'h51;
    localparam logic [7:0]  META_EOT    = 8'h2F;
    localparam logic [7:0]  TEMPO_LEN   = 8'h03;
    localparam logic [23:0] TEMPO_US    = 24'd500000;

    // tick = floor(ms * 24 / 25); ms / 25 = (ms * DIV_MAGIC) >> DIV_SHIFT
    localparam logic [31:0] DIV_MAGIC = 32'h51EB851F;
    localparam int          DIV_SHIFT = 35;
    localparam int          QUOT_W    = 64 - DIV_SHIFT;

    // command queue, depth a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_MSG,
        OP_TEMPO,
        OP_EOT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] delta;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
    } t_cmd;

endpackage

`default_nettype wire

>>> src/mte_front.sv
// Front end: accepts requests, filters messages, converts time to ticks and delta.
`default_nettype none

module mte_front
    import mte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_status_byte,
    input  wire logic [7:0]  i_first_data,
    input  wire logic [7:0]  i_second_data,
    input  wire logic [31:0] i_timestamp_ms,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    output t_cmd             o_cmd,
    output logic             o_push,
    input  wire logic        i_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_TICK,
        F_DELTA,
        F_PUSH
    } t_fstate;

    t_fstate     r_state;
    logic        r_rec_en;
    logic [31:0] r_prev_tick;
    logic [31:0] r_ms;
    logic [63:0] r_prod;
    logic [31:0] r_tick;
    t_cmd        r_cmd;

    logic              w_keep;
    logic [QUOT_W-1:0] w_q;
    logic [32:0]       w_q16;
    logic [32:0]       w_q8;
    logic [32:0]       w_q1;
    logic [32:0]       w_q25;
    logic [32:0]       w_q24;
    logic [31:0]       w_rem_full;
    logic [4:0]        w_rem;
    logic [4:0]        w_adj;
    logic [31:0]       w_tick;

    assign w_keep = r_rec_en && ((i_status_byte[7:4] == CMD_NOTE_OFF) ||
                                 (i_status_byte[7:4] == CMD_NOTE_ON));

    assign w_q        = r_prod[63:DIV_SHIFT];
    assign w_q16      = {w_q, 4'b0000};
    assign w_q8       = {1'b0, w_q, 3'b000};
    assign w_q1       = {4'b0000, w_q};
    assign w_q25      = w_q16 + w_q8 + w_q1;
    assign w_q24      = w_q16 + w_q8;
    assign w_rem_full = r_ms - w_q25[31:0];
    assign w_rem      = w_rem_full[4:0];
    // floor(24 * r / 25) for r below 25
    assign w_adj      = (w_rem == 5'd0) ? 5'd0 : w_rem - 5'd1;
    assign w_tick     = w_q24[31:0] + {27'd0, w_adj};

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH);
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_rec_en    <= 1'b0;
            r_prev_tick <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rec_en <= i_cfg_data;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_ms         <= i_timestamp_ms;
                        r_cmd.status <= i_status_byte;
                        r_cmd.d1     <= i_first_data;
                        r_cmd.d2     <= i_second_data;
                        r_cmd.delta  <= '0;
                        unique case (i_kind)
                            KIND_BEGIN: begin
                                r_cmd.op    <= OP_TEMPO;
                                r_prev_tick <= '0;
                                r_state     <= F_PUSH;
                            end
                            KIND_END: begin
                                r_cmd.op <= OP_EOT;
                                r_state  <= F_PUSH;
                            end
                            KIND_MSG: begin
                                r_cmd.op <= OP_MSG;
                                if (w_keep) begin
                                    r_state <= F_DIV;
                                end
                            end
                            default: begin
                                r_state <= F_IDLE;
                            end
                        endcase
                    end
                end
                F_DIV: begin
                    r_prod  <= 64'(r_ms) * 64'(DIV_MAGIC);
                    r_state <= F_TICK;
                end
                F_TICK: begin
                    r_tick  <= w_tick;
                    r_state <= F_DELTA;
                end
                F_DELTA: begin
                    if (r_tick > r_prev_tick) begin
                        r_cmd.delta <= r_tick - r_prev_tick;
                        r_prev_tick <= r_tick;
                    end
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/mte_queue.sv
// Command queue between the front end and the byte emitter.
`default_nettype none

module mte_queue
    import mte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_head_valid
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_count;

    logic w_wr;
    logic w_rd;

    assign o_full       = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rp];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/mte_back.sv
// Back end: emits a queued command's track bytes, one per cycle while ready.
`default_nettype none

module mte_back
    import mte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_head,
    input  wire logic       i_head_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    logic [2:0] w_nvl;
    logic [3:0] w_total;
    logic       w_end;
    logic       w_load;
    logic [2:0] w_grp;
    logic [2:0] w_tail;
    logic [6:0] w_bits;
    logic [7:0] w_byte;

    // number of variable-length delta bytes
    always_comb begin
        if (i_head.delta[31:28] != '0) begin
            w_nvl = 3'd5;
        end else if (i_head.delta[27:21] != '0) begin
            w_nvl = 3'd4;
        end else if (i_head.delta[20:14] != '0) begin
            w_nvl = 3'd3;
        end else if (i_head.delta[13:7] != '0) begin
            w_nvl = 3'd2;
        end else begin
            w_nvl = 3'd1;
        end
    end

    always_comb begin
        unique case (i_head.op)
            OP_TEMPO: w_total = 4'd7;
            OP_EOT:   w_total = 4'd4;
            default:  w_total = {1'b0, w_nvl} + 4'd3;
        endcase
    end

    assign w_end  = ({1'b0, r_idx} == (w_total - 4'd1));
    assign w_load = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && w_end;
    assign w_grp  = w_nvl - 3'd1 - r_idx;
    assign w_tail = r_idx - w_nvl;

    always_comb begin
        unique case (w_grp)
            3'd4:    w_bits = {3'b000, i_head.delta[31:28]};
            3'd3:    w_bits = i_head.delta[27:21];
            3'd2:    w_bits = i_head.delta[20:14];
            3'd1:    w_bits = i_head.delta[13:7];
            default: w_bits = i_head.delta[6:0];
        endcase
    end

    always_comb begin
        w_byte = 8'h00;
        unique case (i_head.op)
            OP_TEMPO: begin
                unique case (r_idx)
                    3'd1:    w_byte = META_PREFIX;
                    3'd2:    w_byte = META_TEMPO;
                    3'd3:    w_byte = TEMPO_LEN;
                    3'd4:    w_byte = TEMPO_US[23:16];
                    3'd5:    w_byte = TEMPO_US[15:8];
                    3'd6:    w_byte = TEMPO_US[7:0];
                    default: w_byte = 8'h00;
                endcase
            end
            OP_EOT: begin
                unique case (r_idx)
                    3'd1:    w_byte = META_PREFIX;
                    3'd2:    w_byte = META_EOT;
                    default: w_byte = 8'h00;
                endcase
            end
            default: begin
                if (r_idx < w_nvl) begin
                    w_byte = {(w_grp != 3'd0), w_bits};
                end else begin
                    unique case (w_tail)
                        3'd0:    w_byte = i_head.status;
                        3'd1:    w_byte = i_head.d1;
                        default: w_byte = i_head.d2;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_byte  <= w_byte;
                r_last  <= w_end;
                r_idx   <= w_end ? 3'd0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

`default_nettype wire

>>> src/midi_track_event_encoder.sv
// A kept message passes the front end through the divide, tick, delta and push states;
// a begin or end request goes straight to push, and a dropped request makes no command.
// The front end takes no new request until its command is pushed. The byte emitter sends
// one byte per cycle while i_ready is high, 4 to 8 per request.
// Reset (synchronous, active low) clears record_enable, the running tick,
// the command queue and the output register.
`default_nettype none

`include "midi_track_event_encoder_macros.svh"

module midi_track_event_encoder
    import mte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_status_byte,
    input  wire logic [7:0]  i_first_data,
    input  wire logic [7:0]  i_second_data,
    input  wire logic [31:0] i_timestamp_ms,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);

    t_cmd w_cmd;
    logic w_push;
    logic w_full;
    t_cmd w_head;
    logic w_head_valid;
    logic w_pop;
    logic w_meta_req;

    assign w_meta_req = i_valid && o_ready && (i_kind == KIND_BEGIN || i_kind == KIND_END);

    mte_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_status_byte  (i_status_byte),
        .i_first_data   (i_first_data),
        .i_second_data  (i_second_data),
        .i_timestamp_ms (i_timestamp_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (w_cmd),
        .o_push         (w_push),
        .i_full         (w_full)
    );

    mte_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    mte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    `MTE_ASSERT_NEXT(a_pop_marks_last, w_pop, o_valid && o_last, "pop without final byte")
    `MTE_ASSERT_IMPLIES(a_pop_needs_entry, w_pop, w_head_valid, "pop from empty queue")
    `MTE_ASSERT_NEXT(a_meta_busy, w_meta_req, !o_ready, "front idle after meta request")

endmodule

`default_nettype wire
